// ----- rtl/core/fsba_pkg.sv -----
// Shared constants, types and helpers of the fixed-block fit allocator.
package fsba_pkg;

	// Table geometry
	localparam int NUM_BLOCKS = 128;
	localparam int SIZE_BITS  = 16;

	// Port field widths
	localparam int OP_W     = 3;
	localparam int IN_IDX_W = 7;
	localparam int REQ_W    = 16;
	localparam int OUT_IDX_W = 7;

	// Derived widths
	localparam int IDX_W  = (NUM_BLOCKS > 1) ? $clog2(NUM_BLOCKS) : 1;
	localparam int NX_W   = (IDX_W > IN_IDX_W) ? IDX_W : IN_IDX_W;
	localparam int WIDE_W = (SIZE_BITS > REQ_W) ? SIZE_BITS : REQ_W;
	localparam int OXW    = (IDX_W > OUT_IDX_W) ? IDX_W : OUT_IDX_W;

	// Request codes
	localparam logic [OP_W-1:0] OP_LOAD  = 3'd0;
	localparam logic [OP_W-1:0] OP_FIRST = 3'd1;
	localparam logic [OP_W-1:0] OP_BEST  = 3'd2;
	localparam logic [OP_W-1:0] OP_WORST = 3'd3;
	localparam logic [OP_W-1:0] OP_NEXT  = 3'd4;

	// Scan token handed from cell to cell
	typedef struct packed {
		logic                 vld;
		logic                 hit;
		logic                 hi_hit;
		logic [IDX_W-1:0]     pick;
		logic [SIZE_BITS-1:0] best;
	} tok_t;

	// Request context held steady for the length of a scan
	typedef struct packed {
		logic [OP_W-1:0]  op;
		logic [NX_W-1:0]  idx;
		logic             idx_ok;
		logic [REQ_W-1:0] req;
	} req_t;

	// Table updates broadcast to all cells
	typedef struct packed {
		logic                 load_en;
		logic [IDX_W-1:0]     load_idx;
		logic [SIZE_BITS-1:0] load_size;
		logic                 mark_en;
		logic [IDX_W-1:0]     mark_idx;
	} wr_t;

	// Fit a request-width size into a table entry
	function automatic logic [SIZE_BITS-1:0] to_blk_size(input logic [REQ_W-1:0] s);
		logic [WIDE_W-1:0] w;
		w = WIDE_W'(s);
		return w[SIZE_BITS-1:0];
	endfunction

	// Fit a table index onto the result port
	function automatic logic [OUT_IDX_W-1:0] to_out_idx(input logic [IDX_W-1:0] i);
		logic [OXW-1:0] w;
		w = OXW'(i);
		return w[OUT_IDX_W-1:0];
	endfunction

endpackage

// ----- rtl/core/fsba_cell.sv -----
// One table entry with its stage of the scan chain.
module fsba_cell (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic [fsba_pkg::IDX_W-1:0]    cell_idx,
	input  fsba_pkg::req_t                req,
	input  fsba_pkg::wr_t                 wr,
	input  fsba_pkg::tok_t                tok_in,
	output fsba_pkg::tok_t                tok_out
);
	import fsba_pkg::*;

	logic [SIZE_BITS-1:0] size_q;
	logic                 taken_q;
	tok_t                 tok_q;
	tok_t                 tok_nxt;
	logic                 usable;
	logic                 above;
	logic                 below;
	logic                 take;
	logic [NX_W-1:0]      my_idx;

	assign my_idx = NX_W'(cell_idx);
	assign usable = !taken_q && (WIDE_W'(size_q) >= WIDE_W'(req.req));
	assign above  = my_idx > req.idx;
	assign below  = my_idx < req.idx;

	// Decide whether this entry replaces the candidate carried so far
	always_comb begin
		case (req.op)
			OP_FIRST: take = usable && !tok_in.hit;
			OP_BEST:  take = usable && (!tok_in.hit || size_q < tok_in.best);
			OP_WORST: take = usable && (!tok_in.hit || size_q > tok_in.best);
			OP_NEXT: begin
				if (req.idx_ok) begin
					take = usable && ((above && !tok_in.hi_hit) || (below && !tok_in.hit));
				end else begin
					take = usable && !tok_in.hit;
				end
			end
			default: take = 1'b0;
		endcase
	end

	always_comb begin
		tok_nxt        = tok_in;
		tok_nxt.hit    = tok_in.hit | take;
		tok_nxt.hi_hit = tok_in.hi_hit | (take & above & req.idx_ok);
		if (take) begin
			tok_nxt.pick = cell_idx;
			tok_nxt.best = size_q;
		end
	end

	// Advance the token one cell per cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tok_q <= '0;
		end else begin
			tok_q <= tok_nxt;
		end
	end

	// Load a size or mark the entry allocated
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			size_q  <= '0;
			taken_q <= 1'b0;
		end else if (wr.load_en && wr.load_idx == cell_idx) begin
			size_q  <= wr.load_size;
			taken_q <= 1'b0;
		end else if (wr.mark_en && wr.mark_idx == cell_idx) begin
			taken_q <= 1'b1;
		end
	end

	assign tok_out = tok_q;

endmodule

// ----- rtl/core/fsba_chain.sv -----
// Row of table cells linked into one scan chain.
module fsba_chain (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           start,
	input  fsba_pkg::req_t req,
	input  fsba_pkg::wr_t  wr,
	output fsba_pkg::tok_t tail
);
	import fsba_pkg::*;

	tok_t link [NUM_BLOCKS+1];

	// Inject a fresh token at the head of the row
	always_comb begin
		link[0]     = '0;
		link[0].vld = start;
	end

	for (genvar g = 0; g < NUM_BLOCKS; g++) begin : g_cell
		fsba_cell u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.cell_idx (IDX_W'(g)),
			.req      (req),
			.wr       (wr),
			.tok_in   (link[g]),
			.tok_out  (link[g+1])
		);
	end

	assign tail = link[NUM_BLOCKS];

endmodule

// ----- rtl/core/fit_strategy_block_allocator.sv -----
// Fixed-block allocator, top level: request control, result register, table chain.
// Load requests and unused codes skip the scan; the result shows the next cycle.
// Fit requests walk a token through all NUM_BLOCKS cells, one cell per cycle;
// the tail result is held pending, then moved to the output register when it is free.
// One request is in flight at a time; the chain length sets how long a fit takes.
// Reset clears all sizes and allocated marks at once; no clearing pass is needed.
module fit_strategy_block_allocator (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_stall,
	input  logic [fsba_pkg::OP_W-1:0]         op,
	input  logic [fsba_pkg::IN_IDX_W-1:0]     block_index,
	input  logic [fsba_pkg::REQ_W-1:0]        size,
	output logic                              out_valid,
	input  logic                              out_stall,
	output logic                              found,
	output logic [fsba_pkg::OUT_IDX_W-1:0]    chosen_block
);
	import fsba_pkg::*;

	logic                 busy_q;
	logic                 start_q;
	req_t                 req_q;
	logic                 pend_vld_q;
	logic                 pend_found_q;
	logic [IDX_W-1:0]     pend_idx_q;
	logic                 out_valid_q;
	logic                 found_q;
	logic [OUT_IDX_W-1:0] chosen_q;

	logic                 acc;
	logic                 is_scan;
	logic                 load_ok;
	logic                 idx_ok;
	logic                 out_free;
	logic [NX_W-1:0]      idx_nx;
	wr_t                  wr;
	tok_t                 tail;

	assign in_stall = busy_q | (out_valid_q & out_stall);
	assign acc      = in_valid & ~in_stall;
	assign out_free = ~out_valid_q | ~out_stall;
	assign idx_nx   = NX_W'(block_index);
	assign idx_ok   = 32'(block_index) < NUM_BLOCKS;
	assign is_scan  = (op == OP_FIRST) || (op == OP_BEST) || (op == OP_WORST) ||
		(op == OP_NEXT);
	assign load_ok  = (op == OP_LOAD) && idx_ok;

	// Broadcast table updates
	always_comb begin
		wr.load_en   = acc & load_ok;
		wr.load_idx  = idx_nx[IDX_W-1:0];
		wr.load_size = to_blk_size(size);
		wr.mark_en   = tail.vld & tail.hit;
		wr.mark_idx  = tail.pick;
	end

	fsba_chain u_chain (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start_q),
		.req    (req_q),
		.wr     (wr),
		.tail   (tail)
	);

	// Hold the request context while the token travels; capture the result at the tail
	always_ff @(posedge clk) begin
		if (acc && is_scan) begin
			req_q.op     <= op;
			req_q.idx    <= idx_nx;
			req_q.idx_ok <= idx_ok;
			req_q.req    <= size;
		end
		if (tail.vld) begin
			pend_found_q <= tail.hit;
			pend_idx_q   <= tail.pick;
		end
	end

	// Control: busy flag, start pulse, pending scan result, output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q      <= 1'b0;
			start_q     <= 1'b0;
			pend_vld_q  <= 1'b0;
			out_valid_q <= 1'b0;
			found_q     <= 1'b0;
			chosen_q    <= '0;
		end else begin
			start_q <= acc & is_scan;
			if (acc && is_scan) begin
				busy_q <= 1'b1;
			end
			if (tail.vld) begin
				pend_vld_q <= 1'b1;
			end
			if (acc && !is_scan) begin
				out_valid_q <= 1'b1;
				found_q     <= load_ok;
				chosen_q    <= load_ok ? block_index : '0;
			end else if (pend_vld_q && out_free) begin
				out_valid_q <= 1'b1;
				found_q     <= pend_found_q;
				chosen_q    <= to_out_idx(pend_idx_q);
				pend_vld_q  <= 1'b0;
				busy_q      <= 1'b0;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid    = out_valid_q;
	assign found        = found_q;
	assign chosen_block = chosen_q;

	// Allocation marks happen only during a fit request
	assert property (@(posedge clk) disable iff (!arst_n) wr.mark_en |-> busy_q)
		else $error("allocation mark outside a fit request");

	// The token leaving the chain never overlaps a new start
	assert property (@(posedge clk) disable iff (!arst_n) tail.vld |-> !start_q && busy_q)
		else $error("scan token overlaps another scan");

	// A scan starts only with no scan result pending
	assert property (@(posedge clk) disable iff (!arst_n) start_q |-> busy_q && !pend_vld_q)
		else $error("scan started with a result pending");

endmodule

// ----- verif/fit_strategy_block_allocator_test.sv -----
`timescale 1ns / 1ps
// Self-checking testbench of the fixed-block fit allocator: directed table, then random requests.
module fit_strategy_block_allocator_test;
	import fsba_pkg::*;

	// Unused request codes
	localparam logic [OP_W-1:0] OP_SPARE5 = 3'd5;
	localparam logic [OP_W-1:0] OP_SPARE6 = 3'd6;
	localparam logic [OP_W-1:0] OP_SPARE7 = 3'd7;

	localparam int RAND_ITEMS = 1200;
	localparam int HOLD_CYCLES = 700;
	localparam int TAIL_CYCLES = NUM_BLOCKS + 16;
	// Slowest run: every request a full scan, longest gap and longest stall, then several times over
	localparam int LIMIT_CYCLES = 1_000_000;

	typedef struct packed {
		logic                 found;
		logic [OUT_IDX_W-1:0] block;
	} grant_t;

	typedef struct packed {
		logic [OP_W-1:0]      opc;
		logic [IN_IDX_W-1:0]  idx;
		logic [REQ_W-1:0]     sz;
		logic                 typed;
		grant_t               want;
	} req_row_t;

	logic                   clk = 1'b0;
	logic                   arst_n = 1'b0;
	logic                   in_valid;
	logic                   in_stall;
	logic [OP_W-1:0]        op;
	logic [IN_IDX_W-1:0]    block_index;
	logic [REQ_W-1:0]       size;
	logic                   out_valid;
	logic                   out_stall;
	logic                   found;
	logic [OUT_IDX_W-1:0]   chosen_block;

	// Shadow copy of the block table
	logic [SIZE_BITS-1:0]   shadow_size [NUM_BLOCKS];
	logic                   shadow_taken [NUM_BLOCKS];

	grant_t                 grant_q [$];
	int                     errors = 0;
	int                     results_seen = 0;
	int                     cycles = 0;
	int                     burst_left = 0;
	logic                   drain_first = 1'b0;
	logic [OUT_IDX_W-1:0]   last_pick = '0;

	fit_strategy_block_allocator dut (.*);

	always #4 clk = ~clk;

	function automatic logic block_fits(int i, logic [REQ_W-1:0] req);
		return !shadow_taken[i] && shadow_size[i] >= req;
	endfunction

	// Apply one request to the shadow table and return the grant it yields
	function automatic grant_t pick_block(logic [OP_W-1:0] opc, logic [IN_IDX_W-1:0] idx,
			logic [REQ_W-1:0] req);
		grant_t g;
		logic hit;
		int pick;
		int j;
		hit = 1'b0;
		pick = 0;
		case (opc)
			OP_LOAD: begin
				if (int'(idx) < NUM_BLOCKS) begin
					shadow_size[idx] = req[SIZE_BITS-1:0];
					shadow_taken[idx] = 1'b0;
					hit = 1'b1;
					pick = int'(idx);
				end
			end
			OP_FIRST: begin
				for (int i = 0; i < NUM_BLOCKS && !hit; i++)
					if (block_fits(i, req)) begin
						hit = 1'b1;
						pick = i;
					end
			end
			OP_BEST, OP_WORST: begin
				for (int i = 0; i < NUM_BLOCKS; i++)
					if (block_fits(i, req) && (!hit ||
							(opc == OP_BEST && shadow_size[i] < shadow_size[pick]) ||
							(opc == OP_WORST && shadow_size[i] > shadow_size[pick]))) begin
						hit = 1'b1;
						pick = i;
					end
			end
			OP_NEXT: begin
				if (int'(idx) < NUM_BLOCKS) begin
					// scan circularly after the last index, never the index itself
					for (int k = 1; k < NUM_BLOCKS && !hit; k++) begin
						j = (int'(idx) + k) % NUM_BLOCKS;
						if (block_fits(j, req)) begin
							hit = 1'b1;
							pick = j;
						end
					end
				end else begin
					for (int i = 0; i < NUM_BLOCKS && !hit; i++)
						if (block_fits(i, req)) begin
							hit = 1'b1;
							pick = i;
						end
				end
			end
			default: ;
		endcase
		if (hit && opc != OP_LOAD)
			shadow_taken[pick] = 1'b1;
		g.found = hit;
		g.block = hit ? pick[OUT_IDX_W-1:0] : '0;
		return g;
	endfunction

	task automatic flag(string msg);
		errors++;
		if (errors <= 10)
			$display("MISMATCH: %s", msg);
	endtask

	// Idle as the burst pattern says, then offer one request until it is taken
	task automatic send_req(req_row_t rq);
		grant_t g;
		if (drain_first) begin
			in_valid <= 1'b0;
			do @(posedge clk); while (grant_q.size() != 0);
			drain_first = 1'b0;
			burst_left = $urandom_range(1, 16);
		end else if (burst_left == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 20)) @(posedge clk);
			burst_left = ($urandom_range(3) == 0) ? $urandom_range(30, 60) : $urandom_range(1, 16);
		end else begin
			burst_left--;
		end
		op <= rq.opc;
		block_index <= rq.idx;
		size <= rq.sz;
		in_valid <= 1'b1;
		do @(posedge clk); while (in_stall);
		g = pick_block(rq.opc, rq.idx, rq.sz);
		grant_q.push_back(rq.typed ? rq.want : g);
		if (g.found && rq.opc != OP_LOAD)
			last_pick = g.block;
	endtask

	// Check each accepted result against the oldest pending grant
	always @(posedge clk) begin : check_results
		grant_t w;
		if (arst_n && out_valid && !out_stall) begin
			results_seen++;
			if (grant_q.size() == 0) begin
				flag($sformatf("result with no request pending: found=%0d block=%0d",
					found, chosen_block));
			end else begin
				w = grant_q.pop_front();
				if (found !== w.found)
					flag($sformatf("found: expected %0d, got %0d", w.found, found));
				if (chosen_block !== w.block)
					flag($sformatf("chosen_block: expected %0d, got %0d", w.block, chosen_block));
			end
		end
	end

	// Stall the result side on a pattern of its own, with one long hold
	initial begin : stall_results
		int mode;
		int span;
		logic held;
		held = 1'b0;
		out_stall = 1'b0;
		@(posedge clk);
		forever begin
			if (!held && results_seen >= 150) begin
				held = 1'b1;
				out_stall <= 1'b1;
				repeat (HOLD_CYCLES) @(posedge clk);
			end else begin
				mode = $urandom_range(2);
				span = $urandom_range(1, 60);
				for (int c = 0; c < span; c++) begin
					case (mode)
						0: out_stall <= 1'b0;
						1: out_stall <= ($urandom_range(2) == 0);
						default: out_stall <= (c % 4 != 0);
					endcase
					@(posedge clk);
				end
			end
		end
	end

	// Give up on a hung run
	always @(posedge clk) begin
		cycles++;
		if (cycles >= LIMIT_CYCLES) begin
			$display("Test completed with failures");
			$finish;
		end
	end

	initial begin : drive_requests
		req_row_t steps [$];
		req_row_t rq;
		int r;
		int smode;
		in_valid = 1'b0;
		op = OP_LOAD;
		block_index = '0;
		size = '0;
		for (int i = 0; i < NUM_BLOCKS; i++) begin
			shadow_size[i] = '0;
			shadow_taken[i] = 1'b0;
		end

		// Hold reset, then release on an edge
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: empty table, loads, ties, wraparound, skipped index, unused codes
		steps.push_back('{OP_FIRST, 7'd0, 16'd1, 1'b1, '{1'b0, 7'd0}});
		steps.push_back('{OP_BEST, 7'd0, 16'd0, 1'b1, '{1'b1, 7'd0}});
		steps.push_back('{OP_WORST, 7'd5, 16'd0, 1'b0, '{1'b0, 7'd0}});
		steps.push_back('{OP_NEXT, 7'd127, 16'd0, 1'b0, '{1'b0, 7'd0}});
		steps.push_back('{OP_LOAD, 7'd127, 16'hFFFF, 1'b1, '{1'b1, 7'd127}});
		steps.push_back('{OP_LOAD, 7'd0, 16'd0, 1'b1, '{1'b1, 7'd0}});
		steps.push_back('{OP_LOAD, 7'd10, 16'd100, 1'b1, '{1'b1, 7'd10}});
		steps.push_back('{OP_LOAD, 7'd20, 16'd100, 1'b1, '{1'b1, 7'd20}});
		steps.push_back('{OP_LOAD, 7'd30, 16'd50, 1'b1, '{1'b1, 7'd30}});
		steps.push_back('{OP_BEST, 7'd0, 16'd60, 1'b0, '{1'b0, 7'd0}});
		steps.push_back('{OP_WORST, 7'd0, 16'd60, 1'b0, '{1'b0, 7'd0}});
		steps.push_back('{OP_FIRST, 7'd0, 16'hFFFF, 1'b0, '{1'b0, 7'd0}});
		steps.push_back('{OP_NEXT, 7'd20, 16'd40, 1'b0, '{1'b0, 7'd0}});
		steps.push_back('{OP_NEXT, 7'd30, 16'd100, 1'b0, '{1'b0, 7'd0}});
		steps.push_back('{OP_LOAD, 7'd127, 16'hFFFF, 1'b1, '{1'b1, 7'd127}});
		steps.push_back('{OP_NEXT, 7'd127, 16'hFFFF, 1'b0, '{1'b0, 7'd0}});
		steps.push_back('{OP_NEXT, 7'd126, 16'hFFFF, 1'b0, '{1'b0, 7'd0}});
		steps.push_back('{OP_SPARE5, 7'd1, 16'd0, 1'b1, '{1'b0, 7'd0}});
		steps.push_back('{OP_SPARE6, 7'd64, 16'd1, 1'b1, '{1'b0, 7'd0}});
		steps.push_back('{OP_SPARE7, 7'd127, 16'hFFFF, 1'b1, '{1'b0, 7'd0}});
		steps.push_back('{OP_LOAD, 7'd64, 16'h5555, 1'b1, '{1'b1, 7'd64}});
		steps.push_back('{OP_LOAD, 7'd63, 16'hAAAA, 1'b1, '{1'b1, 7'd63}});
		steps.push_back('{OP_FIRST, 7'h55, 16'hAAAA, 1'b0, '{1'b0, 7'd0}});
		steps.push_back('{OP_WORST, 7'h2A, 16'h5555, 1'b0, '{1'b0, 7'd0}});
		foreach (steps[i])
			send_req(steps[i]);

		// Pause until the directed part has fully drained
		drain_first = 1'b1;

		// Random: mostly loads and fits with small sizes, a few wide sizes and spare codes
		for (int n = 0; n < RAND_ITEMS; n++) begin
			r = $urandom_range(99);
			if (r < 45)
				rq.opc = OP_LOAD;
			else if (r < 95)
				case (r % 4)
					0: rq.opc = OP_FIRST;
					1: rq.opc = OP_BEST;
					2: rq.opc = OP_WORST;
					default: rq.opc = OP_NEXT;
				endcase
			else
				case (r % 3)
					0: rq.opc = OP_SPARE5;
					1: rq.opc = OP_SPARE6;
					default: rq.opc = OP_SPARE7;
				endcase
			rq.idx = IN_IDX_W'($urandom_range(NUM_BLOCKS - 1));
			if (rq.opc == OP_NEXT && $urandom_range(1) == 0)
				rq.idx = last_pick;
			smode = $urandom_range(9);
			if (smode < 6)
				rq.sz = REQ_W'($urandom_range(255));
			else if (smode < 8)
				rq.sz = REQ_W'($urandom_range(4095));
			else
				rq.sz = REQ_W'($urandom());
			rq.typed = 1'b0;
			rq.want = '0;
			if (n == RAND_ITEMS / 2)
				drain_first = 1'b1;
			send_req(rq);
		end
		in_valid <= 1'b0;

		// Drain, then let any stray result show
		while (grant_q.size() != 0) @(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);
		if (errors == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule

// ----- filelist.f -----
rtl/core/fsba_pkg.sv
rtl/core/fsba_cell.sv
rtl/core/fsba_chain.sv
rtl/core/fit_strategy_block_allocator.sv
verif/fit_strategy_block_allocator_test.sv
